@@ design/ffba_pkg.sv @@
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

   localparam int ADDR_W = 32;  // payload address width
   localparam int OFF_W  = 21;  // heap offset, block size and limit width
   localparam int REQ_W  = 20;  // request size width

   localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'd4096;
   localparam logic [OFF_W-1:0]  HEAP_LIMIT_RESET = 21'd1048576;

   // configuration register indexes
   localparam logic CSR_HEAP_BASE  = 1'b0;
   localparam logic CSR_HEAP_LIMIT = 1'b1;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_NOMEM   = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_NULL    = 3'd3,
      STAT_UNKNOWN = 3'd4
   } status_type;

   typedef struct packed {
      logic              mode;
      logic [REQ_W-1:0]  request_bytes;
      logic [ADDR_W-1:0] payload_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      status_type        status;
   } rsp_type;

   // one block table entry as stored in the table memory
   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [OFF_W-1:0] size;
      logic             is_free;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_MUL2,
      S_FIX,
      S_SCAN,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;  // latch the request
      logic mul;      // reciprocal multiply, pointer offset
      logic mul2;     // quotient times alignment
      logic fix;      // correct rounding, rewind the scan
      logic scan;     // walk the block table
      logic commit;   // update state, load the response
   } cmd_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_done;
      logic rsp_free;
   } stat_type;

endpackage

@@ design/ffba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ffba_ctrl.sv @@
// Sequencing state machine for the allocator.
module ffba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ffba_pkg::stat_type stat,
   output ffba_pkg::cmd_type  cmd
);

   ffba_pkg::state_type state_ff;
   ffba_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffba_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ffba_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ffba_pkg::S_MUL;
            end
         end
         ffba_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ffba_pkg::S_MUL2;
         end
         ffba_pkg::S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ffba_pkg::S_FIX;
         end
         ffba_pkg::S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ffba_pkg::S_SCAN;
         end
         ffba_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit || stat.scan_done) begin
               state_in = ffba_pkg::S_COMMIT;
            end
         end
         ffba_pkg::S_COMMIT: begin
            // hold until the response register can take the result
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ffba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffba_pkg::S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ffba_pkg::S_IDLE);

endmodule

@@ design/ffba_dp.sv @@
// Datapath: rounding, block table scan, heap state and response register.
module ffba_dp #(
   parameter int MAX_BLOCKS   = 64,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  ffba_pkg::cmd_type  cmd,
   output ffba_pkg::stat_type stat,
   input  ffba_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ffba_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int AW    = ffba_pkg::ADDR_W;
   localparam int OW    = ffba_pkg::OFF_W;
   localparam int PW    = 2 * OW + 1;
   localparam int TW    = OW + 2;
   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   // floor(2^OW / ALIGN) gives a quotient that is exact or one short
   localparam int RECIP_I = (1 << OW) / ALIGN_BYTES;
   localparam int ALIGN_M1_I = ALIGN_BYTES - 1;

   localparam logic [OW:0]      RECIP    = RECIP_I[OW:0];
   localparam logic [OW-1:0]    ALIGN_V  = ALIGN_BYTES[OW-1:0];
   localparam logic [OW-1:0]    ALIGN_M1 = ALIGN_M1_I[OW-1:0];
   localparam logic [OW-1:0]    HDR_OFF  = HEADER_BYTES[OW-1:0];
   localparam logic [AW-1:0]    HDR_ADDR = HEADER_BYTES[AW-1:0];
   localparam logic [CNT_W-1:0] MAX_CNT  = MAX_BLOCKS[CNT_W-1:0];

   // request and rounding
   logic                mode_ff, mode_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [OW-1:0]       m_ff, m_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [AW-1:0]       off_ff, off_in;
   logic [OW-1:0]       qa_ff, qa_in;
   logic [OW-1:0]       need_ff, need_in;
   logic [2*OW-1:0]     qa_full;
   logic [OW-1:0]       q_est;
   logic [OW-1:0]       rem;

   // scan
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pidx_ff, pidx_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   ffba_pkg::entry_type hit_ent_ff, hit_ent_in;
   logic                match;

   // heap state and configuration
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OW-1:0]       break_ff, break_in;
   logic [AW-1:0]       base_ff, base_in;
   logic [OW-1:0]       limit_ff, limit_in;
   logic [TW-1:0]       total;

   // response
   logic                rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // table memory
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   ffba_pkg::entry_type ram_wr_ent;
   logic                ram_rd_en;
   ffba_pkg::entry_type rd_ent;

   ffba_ram #(
      .WIDTH ($bits(ffba_pkg::entry_type)),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_ent),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_ent)
   );

   // rounding and pointer offset
   always_comb begin
      mode_in = mode_ff;
      addr_in = addr_ff;
      m_in    = m_ff;
      prod_in = prod_ff;
      off_in  = off_ff;
      qa_in   = qa_ff;
      need_in = need_ff;
      q_est   = prod_ff[2*OW-1:OW];
      qa_full = (2*OW)'(q_est) * (2*OW)'(ALIGN_V);
      rem     = m_ff - qa_ff;
      if (cmd.capture) begin
         mode_in = req_data.mode;
         addr_in = req_data.payload_address;
         m_in    = OW'(req_data.request_bytes) + ALIGN_M1;
      end
      if (cmd.mul) begin
         prod_in = PW'(m_ff) * PW'(RECIP);
         off_in  = addr_ff - base_ff - HDR_ADDR;
      end
      if (cmd.mul2) begin
         qa_in = qa_full[OW-1:0];
      end
      if (cmd.fix) begin
         need_in = (rem >= ALIGN_V) ? (qa_ff + ALIGN_V) : qa_ff;
      end
   end

   // table scan: one read issued per cycle, compare on the registered data
   always_comb begin
      if (mode_ff == ffba_pkg::MODE_FREE) begin
         match = (AW'(rd_ent.start) == off_ff);
      end else begin
         match = rd_ent.is_free && (rd_ent.size >= need_ff);
      end
      stat.scan_hit  = pend_ff && match;
      stat.scan_done = !pend_ff && (idx_ff == count_ff);
      stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

      ram_rd_en  = cmd.scan && (idx_ff != count_ff);
      idx_in     = idx_ff;
      pend_in    = 1'b0;
      pidx_in    = idx_ff[IDX_W-1:0];
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_ent_in = hit_ent_ff;
      if (cmd.fix) begin
         idx_in = '0;
         hit_in = 1'b0;
      end
      if (ram_rd_en) begin
         idx_in  = idx_ff + CNT_W'(1);
         pend_in = 1'b1;
      end
      if (cmd.scan && stat.scan_hit) begin
         hit_in     = 1'b1;
         hit_idx_in = pidx_ff;
         hit_ent_in = rd_ent;
      end
   end

   // commit: state update and response
   always_comb begin
      total       = TW'(break_ff) + TW'(HDR_OFF) + TW'(need_ff);
      count_in    = count_ff;
      break_in    = break_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = hit_idx_ff;
      ram_wr_ent  = hit_ent_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.commit) begin
         rsp_data_in.result_address = '0;
         rsp_data_in.status         = ffba_pkg::STAT_OK;
         if (mode_ff == ffba_pkg::MODE_ALLOC) begin
            if (hit_ff) begin
               ram_wr_en          = 1'b1;
               ram_wr_ent.is_free = 1'b0;
               rsp_data_in.result_address = base_ff + AW'(hit_ent_ff.start) + HDR_ADDR;
            end else if (count_ff == MAX_CNT) begin
               rsp_data_in.status = ffba_pkg::STAT_FULL;
            end else if (total > TW'(limit_ff)) begin
               rsp_data_in.status = ffba_pkg::STAT_NOMEM;
            end else begin
               // append at the break
               ram_wr_en          = 1'b1;
               ram_wr_addr        = count_ff[IDX_W-1:0];
               ram_wr_ent.start   = break_ff;
               ram_wr_ent.size    = need_ff;
               ram_wr_ent.is_free = 1'b0;
               count_in           = count_ff + CNT_W'(1);
               break_in           = total[OW-1:0];
               rsp_data_in.result_address = base_ff + AW'(break_ff) + HDR_ADDR;
            end
         end else begin
            if (addr_ff == '0) begin
               rsp_data_in.status = ffba_pkg::STAT_NULL;
            end else if (!hit_ff) begin
               rsp_data_in.status = ffba_pkg::STAT_UNKNOWN;
            end else if ((CNT_W'(hit_idx_ff) + CNT_W'(1)) == count_ff) begin
               // top block: drop it and lower the break
               count_in = count_ff - CNT_W'(1);
               break_in = hit_ent_ff.start;
            end else begin
               ram_wr_en          = 1'b1;
               ram_wr_ent.is_free = 1'b1;
            end
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // configuration
   always_comb begin
      base_in  = base_ff;
      limit_in = limit_ff;
      if (csr_valid) begin
         case (csr_index)
            ffba_pkg::CSR_HEAP_BASE:  base_in  = csr_wdata;
            ffba_pkg::CSR_HEAP_LIMIT: limit_in = csr_wdata[OW-1:0];
            default: begin
               base_in  = base_ff;
               limit_in = limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         count_ff     <= '0;
         break_ff     <= '0;
         base_ff      <= ffba_pkg::HEAP_BASE_RESET;
         limit_ff     <= ffba_pkg::HEAP_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         count_ff     <= count_in;
         break_ff     <= break_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      addr_ff     <= addr_in;
      m_ff        <= m_in;
      prod_ff     <= prod_in;
      off_ff      <= off_in;
      qa_ff       <= qa_in;
      need_ff     <= need_in;
      pidx_ff     <= pidx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ent_ff  <= hit_ent_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/first_fit_block_allocator.sv @@
// Top level of the first-fit block allocator with a break pointer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------
//   req      | req_valid/req_stall  | req_data  (mode, size, pointer)
//   rsp      | rsp_valid/rsp_stall  | rsp_data  (address, status)
//   csr      | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One request at a time: the time from acceptance to the response register is
// set by the table scan through the single read port of the block table
// memory (one entry per cycle) plus the rounding multiplies.
// Synchronous reset empties the heap; the table needs no clearing pass.
// A response held by rsp_stall does not block the next request from being
// accepted; that request waits at its final step until the response leaves.
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffba_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   ffba_pkg::cmd_type  cmd;
   ffba_pkg::stat_type stat;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffba_dp #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   assign csr_ready = 1'b1;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted without the block going busy");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.rsp_free)
      else $error("commit while the response register is still held");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not present a response");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ffba_pkg::STAT_OK) |->
         (rsp_data.result_address == '0))
      else $error("failed request returned a nonzero address");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.mul, cmd.mul2, cmd.fix, cmd.scan, cmd.commit}))
      else $error("more than one command at once");

endmodule
